[rtl/core/bhos_pkg.sv]
// ----------------------------------------------------------------------------
// Byte histogram order statistics: shared types
// Item structs for the sample and result channels, and the sequencer states.
// ----------------------------------------------------------------------------
package bhos_pkg;

   // One sample of a set
   typedef struct packed {
      logic [7:0] sample;
      logic       last;
   } bhos_req_type;

   // One result, produced at the end of each set
   typedef struct packed {
      logic [7:0]  mode_value;
      logic [7:0]  min_value;
      logic [7:0]  max_value;
      logic [7:0]  spread;
      logic [8:0]  median_doubled;
      logic [7:0]  lower_quartile;
      logic [7:0]  upper_quartile;
      logic        quartiles_valid;
      logic [23:0] sample_sum;
      logic [15:0] sample_count;
      logic        overflow;
   } bhos_rsp_type;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_CLEAR,   // zeroing the bin memory after reset
      ST_RUN,     // counting samples
      ST_WALK,    // reading and clearing bins in order
      ST_EMIT     // waiting to load the result register
   } bhos_state_type;

endpackage

[rtl/core/byte_histogram_order_stats.sv]
// ----------------------------------------------------------------------------
// Byte histogram order statistics
// Counts byte samples into a bin memory and reports mode, min, max, spread, median,
// quartiles, sum, count and overflow at the end of each set.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one sample per item, last marks the final sample of a set.
//   rsp channel: one result item per set, after the last sample.
//   During a set one sample is taken every cycle. Each sample reads its bin
//   into the read register at accept and the update stage writes the
//   incremented count back; a repeat of the same bin on the next cycle is
//   forwarded from the pending write. After the last sample req_stall
//   rises while the block finishes the last bin update, reads and zeroes
//   every bin (one memory read a cycle), retires the final bin and loads the
//   result. The result register then holds the item until it is taken; the
//   next set can start counting while it waits.
//   A result that cannot be loaded because rsp_stall holds the previous one
//   keeps req_stall high until the register frees.
//   Samples beyond a count of 2^COUNT_BITS - 1 are dropped and flagged.
//   Reset: synchronous. A clearing pass zeroes every bin of the memory,
//   with req_stall high, before the first sample is taken.
// ----------------------------------------------------------------------------
module byte_histogram_order_stats #(
   parameter int BIN_COUNT  = 256,
   parameter int COUNT_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  bhos_pkg::bhos_req_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output bhos_pkg::bhos_rsp_type rsp_item
);
   import bhos_pkg::*;

   localparam int BIN_W  = $clog2(BIN_COUNT);
   localparam int VAL_W  = (BIN_W > 9) ? BIN_W : 9;
   localparam int RANK_W = COUNT_BITS + 2;
   localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(BIN_COUNT - 1);

   // Bin memory
   logic [COUNT_BITS-1:0] bin_mem [BIN_COUNT];
   logic [BIN_W-1:0]      rd_addr;
   logic [COUNT_BITS-1:0] rd_data_ff;
   logic                  wr_en;
   logic [BIN_W-1:0]      wr_addr;
   logic [COUNT_BITS-1:0] wr_data;

   bhos_state_type state_ff, state_in;

   // Accept and sample binning
   logic             req_accept;
   logic [VAL_W-1:0] sample_x;
   logic [VAL_W-1:0] sample_sat;
   logic [BIN_W-1:0] sample_bin;
   logic             count_full;

   // Set registers
   logic [COUNT_BITS-1:0] count_ff;
   logic [23:0]           sum_ff;
   logic                  overflow_ff;

   // Update stage: bin read issued at accept, written back in the following cycle
   logic                  upd_valid_ff;
   logic                  upd_last_ff;
   logic [BIN_W-1:0]      upd_bin_ff;
   logic                  fwd_valid_ff;
   logic [BIN_W-1:0]      fwd_bin_ff;
   logic [COUNT_BITS-1:0] fwd_data_ff;
   logic [COUNT_BITS-1:0] upd_base;
   logic [COUNT_BITS-1:0] upd_count;

   // Walk
   logic [BIN_W-1:0]      idx_ff;
   logic                  idx_end;
   logic                  wk_valid_ff;
   logic [BIN_W-1:0]      wk_bin_ff;
   logic [RANK_W-1:0]     n_x;
   logic [RANK_W-1:0]     med_a_ff, med_b_ff, lq_rank_ff, uq_rank_ff;
   logic [RANK_W-1:0]     cum_ff, cum_in;
   logic [COUNT_BITS-1:0] best_ff;
   logic                  seen_ff;
   logic [BIN_W-1:0]      mode_ff, lo_ff, hi_ff, va_ff, vb_ff, vlq_ff, vuq_ff;
   logic                  walk_start;

   // Result
   logic                  rsp_valid_ff;
   bhos_rsp_type          rsp_item_ff, rsp_item_in;
   logic                  rsp_free;
   logic                  emit_go;
   logic                  lq_ok, uq_ok;
   logic [VAL_W-1:0]      mode_x, lo_x, hi_x, va_x, vb_x, vlq_x, vuq_x;
   logic [VAL_W-1:0]      spread_x, med_x;
   logic [31:0]           count_x;

   // Handshakes
   assign req_stall  = (state_ff != ST_RUN) || upd_last_ff;
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign idx_end    = (idx_ff == LAST_BIN);
   assign walk_start = (state_ff == ST_RUN) && upd_last_ff;
   assign emit_go    = (state_ff == ST_EMIT) && !wk_valid_ff && rsp_free;

   // Saturate the sample to the top bin for narrow histograms
   always_comb begin
      sample_x = VAL_W'(req_item.sample);
      if (sample_x > VAL_W'(BIN_COUNT - 1)) begin
         sample_sat = VAL_W'(BIN_COUNT - 1);
      end else begin
         sample_sat = sample_x;
      end
      sample_bin = sample_sat[BIN_W-1:0];
   end

   assign count_full = (count_ff == {COUNT_BITS{1'b1}});

   // Sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (idx_end) state_in = ST_RUN;
         end
         ST_RUN: begin
            if (upd_last_ff) state_in = ST_WALK;
         end
         ST_WALK: begin
            if (idx_end) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (emit_go) state_in = ST_RUN;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // Bin index for the clearing pass and the walk
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else if (state_ff == ST_CLEAR || state_ff == ST_WALK) begin
         idx_ff <= idx_end ? '0 : idx_ff + BIN_W'(1);
      end
   end

   // Memory ports
   assign rd_addr = (state_ff == ST_WALK) ? idx_ff : sample_bin;

   // Forward a write made on the same edge as this item's read
   always_comb begin
      if (fwd_valid_ff && fwd_bin_ff == upd_bin_ff) begin
         upd_base = fwd_data_ff;
      end else begin
         upd_base = rd_data_ff;
      end
      upd_count = upd_base + COUNT_BITS'(1);
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = upd_bin_ff;
      wr_data = '0;
      if (state_ff == ST_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = idx_ff;
      end else if (wk_valid_ff) begin
         wr_en   = 1'b1;
         wr_addr = wk_bin_ff;
      end else if (upd_valid_ff) begin
         wr_en   = 1'b1;
         wr_data = upd_count;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= bin_mem[rd_addr];
      if (wr_en) bin_mem[wr_addr] <= wr_data;
   end

   // Update stage and forwarding registers
   always_ff @(posedge clock) begin
      if (reset) begin
         upd_valid_ff <= 1'b0;
         upd_last_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
      end else begin
         upd_valid_ff <= req_accept && !count_full;
         upd_last_ff  <= req_accept && req_item.last;
         fwd_valid_ff <= upd_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      upd_bin_ff  <= sample_bin;
      fwd_bin_ff  <= upd_bin_ff;
      fwd_data_ff <= upd_count;
   end

   // Count, sum and overflow of the current set
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         sum_ff      <= '0;
         overflow_ff <= 1'b0;
      end else if (emit_go) begin
         count_ff    <= '0;
         sum_ff      <= '0;
         overflow_ff <= 1'b0;
      end else if (req_accept) begin
         if (count_full) begin
            overflow_ff <= 1'b1;
         end else begin
            count_ff <= count_ff + COUNT_BITS'(1);
            sum_ff   <= sum_ff + 24'(sample_sat);
         end
      end
   end

   // Ranks are fixed once the last bin update is in
   assign n_x = RANK_W'(count_ff);

   always_ff @(posedge clock) begin
      if (walk_start) begin
         med_a_ff   <= (n_x + RANK_W'(1)) >> 1;
         med_b_ff   <= (n_x >> 1) + RANK_W'(1);
         lq_rank_ff <= (n_x + RANK_W'(3)) >> 2;
         uq_rank_ff <= ((n_x << 1) + n_x + RANK_W'(5)) >> 2;
      end
   end

   // Walk stage: one bin retired per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         wk_valid_ff <= 1'b0;
      end else begin
         wk_valid_ff <= (state_ff == ST_WALK);
      end
   end

   always_ff @(posedge clock) begin
      wk_bin_ff <= idx_ff;
   end

   assign cum_in = cum_ff + RANK_W'(rd_data_ff);

   always_ff @(posedge clock) begin
      if (walk_start) begin
         cum_ff  <= '0;
         best_ff <= '0;
         seen_ff <= 1'b0;
         mode_ff <= '0;
         lo_ff   <= '0;
         hi_ff   <= '0;
         va_ff   <= '0;
         vb_ff   <= '0;
         vlq_ff  <= '0;
         vuq_ff  <= '0;
      end else if (wk_valid_ff) begin
         cum_ff <= cum_in;
         if (rd_data_ff != '0) begin
            if (!seen_ff) lo_ff <= wk_bin_ff;
            seen_ff <= 1'b1;
            hi_ff   <= wk_bin_ff;
         end
         // strict compare keeps the lowest value on a tie
         if (rd_data_ff > best_ff) begin
            best_ff <= rd_data_ff;
            mode_ff <= wk_bin_ff;
         end
         if (med_a_ff > cum_ff && med_a_ff <= cum_in) va_ff <= wk_bin_ff;
         if (med_b_ff > cum_ff && med_b_ff <= cum_in) vb_ff <= wk_bin_ff;
         if (lq_rank_ff > cum_ff && lq_rank_ff <= cum_in) vlq_ff <= wk_bin_ff;
         if (uq_rank_ff > cum_ff && uq_rank_ff <= cum_in) vuq_ff <= wk_bin_ff;
      end
   end

   // Result assembly
   always_comb begin
      lq_ok    = (lq_rank_ff != '0) && (lq_rank_ff <= n_x);
      uq_ok    = (uq_rank_ff != '0) && (uq_rank_ff <= n_x);
      mode_x   = VAL_W'(mode_ff);
      lo_x     = VAL_W'(lo_ff);
      hi_x     = VAL_W'(hi_ff);
      va_x     = VAL_W'(va_ff);
      vb_x     = VAL_W'(vb_ff);
      vlq_x    = VAL_W'(vlq_ff);
      vuq_x    = VAL_W'(vuq_ff);
      spread_x = hi_x - lo_x;
      med_x    = va_x + vb_x;
      count_x  = 32'(count_ff);

      rsp_item_in.mode_value      = mode_x[7:0];
      rsp_item_in.min_value       = lo_x[7:0];
      rsp_item_in.max_value       = hi_x[7:0];
      rsp_item_in.spread          = spread_x[7:0];
      rsp_item_in.median_doubled  = (count_ff != '0) ? med_x[8:0] : 9'd0;
      rsp_item_in.lower_quartile  = lq_ok ? vlq_x[7:0] : 8'd0;
      rsp_item_in.upper_quartile  = uq_ok ? vuq_x[7:0] : 8'd0;
      rsp_item_in.quartiles_valid = lq_ok && uq_ok;
      rsp_item_in.sample_sum      = sum_ff;
      rsp_item_in.sample_count    = count_x[15:0];
      rsp_item_in.overflow        = overflow_ff;
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_go) rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

[rtl/core/bhos_checker.sv]
// ----------------------------------------------------------------------------
// Byte histogram order statistics: port checker
// Watches the top level's ports for handshake and result consistency.
// ----------------------------------------------------------------------------
module bhos_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input bhos_pkg::bhos_req_type req_item,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input bhos_pkg::bhos_rsp_type rsp_item
);
   import bhos_pkg::*;

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
      else $error("result item changed while stalled");

   // The bin memory is being cleared right after reset
   a_reset_stall: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("sample taken during the clearing pass");

   // The end of a set starts the walk, so no sample follows at once
   a_last_stall: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_item.last |=> req_stall)
      else $error("sample taken straight after the last of a set");

   // Spread agrees with min and max, and the upper quartile reads as zero when the quartiles are not valid
   a_result_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.spread == 8'(rsp_item.max_value - rsp_item.min_value))
                    && (rsp_item.quartiles_valid || rsp_item.upper_quartile == 8'd0))
      else $error("inconsistent result item");

endmodule

bind byte_histogram_order_stats bhos_checker u_bhos_checker (.*);
